>>> rtl/llt_pkg.sv
// Shared types and codes for the link liveness tracker.
// Depends on nothing; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package llt_pkg;

   // Event codes carried in the op field.
   typedef enum logic [2:0] {
      OP_MSG_START   = 3'd0,
      OP_MSG_VALID   = 3'd1,
      OP_MSG_ERROR   = 3'd2,
      OP_LINK_UP     = 3'd3,
      OP_LINK_LOST   = 3'd4,
      OP_ACTIVITY    = 3'd5,
      OP_STALE_CHECK = 3'd6,
      OP_CONFIG_SENT = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      LINK_DISCONNECTED = 2'd0,
      LINK_CONNECTED    = 2'd1,
      LINK_ACTIVE       = 2'd2,
      LINK_STALE        = 2'd3
   } link_state_type;

   typedef enum logic [1:0] {
      PHASE_IDLE       = 2'd0,
      PHASE_PROCESSING = 2'd1,
      PHASE_VALID      = 2'd2,
      PHASE_ERROR      = 2'd3
   } message_phase_type;

   // CSR map: register i at byte address 4*i; bit 2 selects the register.
   localparam int  CSR_ADDR_WIDTH       = 3;
   localparam logic REG_SEL_STALE_TIMEOUT = 1'b0;
   localparam logic REG_SEL_GRACE_WINDOW  = 1'b1;
   localparam logic [31:0] STALE_TIMEOUT_RESET = 32'd1000;
   localparam logic [31:0] GRACE_WINDOW_RESET  = 32'd0;

   typedef struct packed {
      op_type      op;
      logic [7:0]  msg_kind;
      logic [31:0] sequence_req;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      link_state_type    link_state;
      message_phase_type message_phase;
      logic [7:0]        last_type;
      logic [31:0]       last_sequence;
      logic [31:0]       total_count;
      logic [31:0]       valid_count;
      logic [31:0]       error_count;
      logic [31:0]       stale_count;
      logic              went_stale;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/link_liveness_tracker_top.sv
// Link liveness tracker: top level with event datapath, CSRs and beat flow control.
// Depends on llt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted request beat is one link event (message start/valid/error,
// link up/lost, activity, stale check, config sent) stamped with now_ms. The
// block answers every request beat with exactly one response beat holding the
// link state, message phase, last message type and sequence, the four event
// counters (low 32 bits) and a went_stale flag, all as they stand after that
// event. Throughput is one beat per clock while rsp_stall does not block the
// response register. An accepted request beat sits in the input register;
// when it fires, the event logic (three 32-bit subtracts, a 33-bit add and
// compares) updates the tracker state and loads the response register. A
// new request is taken while a finished response is still waiting; req_stall
// only rises when both the input register and the response register are full
// and rsp_stall is high. The stale timeout (address 0x0, reset 1000) and the
// grace window (address 0x4, reset 0) are written over the APB-style port;
// the user must write them only while no event is in flight, which the block
// does not enforce. Time differences wrap modulo 2^32; the grace-extended
// timeout is compared at 33 bits. A recorded time of zero means "never".
// Counters are COUNT_WIDTH bits wide and wrap.
module link_liveness_tracker_top #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  llt_pkg::req_type               req_data,
   // response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output llt_pkg::rsp_type                     rsp_data,
   // configuration port
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire  [llt_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire  [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   import llt_pkg::*;

   // ---------------- configuration registers ----------------
   logic [31:0] stale_timeout_ff;
   logic [31:0] grace_window_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_timeout_ff <= STALE_TIMEOUT_RESET;
         grace_window_ff  <= GRACE_WINDOW_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_SEL_STALE_TIMEOUT) begin
            stale_timeout_ff <= pwdata;
         end else begin
            grace_window_ff <= pwdata;
         end
      end
   end

   assign prdata = (paddr[2] == REG_SEL_GRACE_WINDOW) ? grace_window_ff : stale_timeout_ff;

   // ---------------- flow control ----------------
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    out_busy;
   logic    fire;

   // Response register is blocked only when it holds a beat that is stalled.
   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign fire      = in_valid_ff & ~out_busy;
   assign req_stall = in_valid_ff & out_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!out_busy) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // ---------------- tracker state ----------------
   link_state_type    link_state_ff,    link_state_in;
   message_phase_type message_phase_ff, message_phase_in;
   logic [7:0]             last_type_ff,     last_type_in;
   logic [31:0]            last_sequence_ff, last_sequence_in;
   logic [COUNT_WIDTH-1:0] total_count_ff,   total_count_in;
   logic [COUNT_WIDTH-1:0] valid_count_ff,   valid_count_in;
   logic [COUNT_WIDTH-1:0] error_count_ff,   error_count_in;
   logic [COUNT_WIDTH-1:0] stale_count_ff,   stale_count_in;
   logic [31:0]            activity_time_ff, activity_time_in;
   logic [31:0]            config_time_ff,   config_time_in;
   logic                   went_stale;

   // Stale check arithmetic: ages wrap at 32 bits, limit is 33 bits.
   logic [31:0] since_config;
   logic [31:0] activity_age;
   logic        in_grace;
   logic [32:0] stale_limit;
   logic        timed_out;

   assign since_config = in_data_ff.now_ms - config_time_ff;
   assign activity_age = in_data_ff.now_ms - activity_time_ff;
   assign in_grace     = (grace_window_ff != 32'd0) && (config_time_ff != 32'd0)
                         && (since_config < grace_window_ff);
   assign stale_limit  = {1'b0, stale_timeout_ff}
                         + (in_grace ? {1'b0, grace_window_ff - since_config} : 33'd0);
   assign timed_out    = {1'b0, activity_age} > stale_limit;

   always_comb begin
      link_state_in    = link_state_ff;
      message_phase_in = message_phase_ff;
      last_type_in     = last_type_ff;
      last_sequence_in = last_sequence_ff;
      total_count_in   = total_count_ff;
      valid_count_in   = valid_count_ff;
      error_count_in   = error_count_ff;
      stale_count_in   = stale_count_ff;
      activity_time_in = activity_time_ff;
      config_time_in   = config_time_ff;
      went_stale       = 1'b0;
      case (in_data_ff.op)
         OP_MSG_START: begin
            message_phase_in = PHASE_PROCESSING;
            last_type_in     = in_data_ff.msg_kind;
            last_sequence_in = in_data_ff.sequence_req;
            total_count_in   = total_count_ff + COUNT_WIDTH'(1);
         end
         OP_MSG_VALID: begin
            message_phase_in = PHASE_VALID;
            valid_count_in   = valid_count_ff + COUNT_WIDTH'(1);
         end
         OP_MSG_ERROR: begin
            message_phase_in = PHASE_ERROR;
            error_count_in   = error_count_ff + COUNT_WIDTH'(1);
         end
         OP_LINK_UP: begin
            link_state_in    = LINK_CONNECTED;
            activity_time_in = in_data_ff.now_ms;
         end
         OP_LINK_LOST: begin
            link_state_in    = LINK_DISCONNECTED;
            message_phase_in = PHASE_IDLE;
         end
         OP_ACTIVITY: begin
            link_state_in    = LINK_ACTIVE;
            activity_time_in = in_data_ff.now_ms;
         end
         OP_STALE_CHECK: begin
            // only an active link with a recorded activity time can go stale
            if (link_state_ff == LINK_ACTIVE && activity_time_ff != 32'd0 && timed_out) begin
               link_state_in  = LINK_STALE;
               stale_count_in = stale_count_ff + COUNT_WIDTH'(1);
               went_stale     = 1'b1;
            end
         end
         OP_CONFIG_SENT: begin
            config_time_in = in_data_ff.now_ms;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff    <= LINK_DISCONNECTED;
         message_phase_ff <= PHASE_IDLE;
         last_type_ff     <= '0;
         last_sequence_ff <= '0;
         total_count_ff   <= '0;
         valid_count_ff   <= '0;
         error_count_ff   <= '0;
         stale_count_ff   <= '0;
         activity_time_ff <= '0;
         config_time_ff   <= '0;
      end else if (fire) begin
         link_state_ff    <= link_state_in;
         message_phase_ff <= message_phase_in;
         last_type_ff     <= last_type_in;
         last_sequence_ff <= last_sequence_in;
         total_count_ff   <= total_count_in;
         valid_count_ff   <= valid_count_in;
         error_count_ff   <= error_count_in;
         stale_count_ff   <= stale_count_in;
         activity_time_ff <= activity_time_in;
         config_time_ff   <= config_time_in;
      end
   end

   // Response payload: counters show their low 32 bits (zero-extended if narrower).
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff.link_state    <= link_state_in;
         rsp_data_ff.message_phase <= message_phase_in;
         rsp_data_ff.last_type     <= last_type_in;
         rsp_data_ff.last_sequence <= last_sequence_in;
         rsp_data_ff.total_count   <= 32'(total_count_in);
         rsp_data_ff.valid_count   <= 32'(valid_count_in);
         rsp_data_ff.error_count   <= 32'(error_count_in);
         rsp_data_ff.stale_count   <= 32'(stale_count_in);
         rsp_data_ff.went_stale    <= went_stale;
      end
   end

endmodule

`default_nettype wire

>>> rtl/llt_checker.sv
// Port-level checker for the link liveness tracker, plus its bind.
// Depends on llt_pkg and link_liveness_tracker_top.
`timescale 1ns / 1ps
`default_nettype none

module llt_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input wire llt_pkg::rsp_type rsp_data
);

   import llt_pkg::*;

   // nothing comes out in the cycle after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

   // a stalled response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // a beat that reports going stale shows the link stale
   a_went_stale_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.went_stale |-> rsp_data.link_state == LINK_STALE)
      else $error("went_stale without stale link state");

   // an accepted request passes the input and response registers to the response port if unblocked
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("accepted request did not produce a response");

endmodule

bind link_liveness_tracker_top llt_checker u_llt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
